// ===== src/mexp_pkg.sv =====
// Shared constants, operation codes and controller/datapath interface types.
package mexp_pkg;

	localparam int FIELD_W    = 32;  // port width of message, result and registers
	localparam int MEXP_WIDTH = 32;  // default operand width
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = 1'b1;

	typedef enum logic [1:0] {
		OP_REDUCE = 2'd0,  // message * 1 mod n -> base
		OP_MUL    = 2'd1,  // acc * base mod n  -> acc
		OP_SQR    = 2'd2   // base * base mod n -> base
	} op_t;

	typedef struct packed {
		logic load;       // capture message, copy registers, acc = 1
		logic clear;      // acc = 0 (modulus below two)
		logic mul_start;  // launch modular multiply
		op_t  op;         // operand selection for the launch
		logic shift;      // advance to next exponent bit
	} cmd_t;

	typedef struct packed {
		logic mul_busy;
		logic mul_done;
		logic e_bit;      // current exponent bit
		logic last_bit;   // current bit is the top one
		logic n_small;    // latched modulus below two
	} status_t;

endpackage

// ===== src/modular_exponentiation.sv =====
// Top level: modular exponentiation by right-to-left square and multiply.
//
// A request is taken when start is high and busy is low; it carries one message
// value and returns message ** exponent mod modulus on result, valid for exactly
// one cycle while done is high. The receiver cannot stall, so capture result
// whenever done is seen. Modulus and exponent are written through the cfg_* port
// (index 0 modulus, reset 2; index 1 exponent, reset 1); the user must write them
// only while the block is idle, which the block does not enforce. A modulus below
// two yields 0 and an exponent of zero yields 1. One request is processed at a
// time. All arithmetic goes through a single iterative modular multiplier that
// consumes one multiplier bit per cycle, VW = min(WIDTH, 32) bits per product.
// A new request may be presented in the cycle done is high.
module modular_exponentiation #(
	parameter int WIDTH = mexp_pkg::MEXP_WIDTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write port
	input  logic                            cfg_we,
	input  logic [mexp_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  logic [mexp_pkg::FIELD_W-1:0]    cfg_wdata,
	// request
	input  logic                            start,
	input  logic [mexp_pkg::FIELD_W-1:0]    message,
	output logic                            busy,
	// result strobe
	output logic                            done,
	output logic [mexp_pkg::FIELD_W-1:0]    result
);
	import mexp_pkg::*;

	cmd_t    cmd;     // controller -> datapath
	status_t status;  // datapath -> controller

	// controller: one-hot FSM stepping through reduce, then multiply/square per bit
	mexp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// datapath: registers, exponent scan, shared modular multiplier; result holds
	// the accumulator, which is final while done is high
	mexp_datapath #(.WIDTH(WIDTH)) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.message   (message),
		.cmd       (cmd),
		.status    (status),
		.result    (result)
	);

endmodule

// ===== src/mexp_mulmod.sv =====
// Iterative interleaved modular multiplier, one multiplier bit per cycle.
module mexp_mulmod #(
	parameter int VW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [VW-1:0] a,
	input  logic [VW-1:0] b,   // must be below n
	input  logic [VW-1:0] n,
	output logic          busy,
	output logic          done,
	output logic [VW-1:0] p
);
	localparam int CW = $clog2(VW);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [VW-1:0] a_q;
	logic [VW-1:0] b_q;
	logic [VW-1:0] n_q;
	logic [VW-1:0] r_q;

	logic [VW:0] dbl;
	logic [VW:0] dbl_red;
	logic [VW:0] sum;
	logic [VW:0] sum_red;

	// r = 2r mod n, then r = r + b mod n if the multiplier bit is set
	always_comb begin
		dbl     = {r_q, 1'b0};
		dbl_red = (dbl >= {1'b0, n_q}) ? dbl - {1'b0, n_q} : dbl;
		sum     = dbl_red + (a_q[VW-1] ? {1'b0, b_q} : '0);
		sum_red = (sum >= {1'b0, n_q}) ? sum - {1'b0, n_q} : sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(VW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			a_q <= a;
			b_q <= b;
			n_q <= n;
			r_q <= '0;
		end else if (busy_q) begin
			a_q <= {a_q[VW-2:0], 1'b0};
			r_q <= sum_red[VW-1:0];
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign p    = r_q;

	a_rem_below_mod: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (r_q < n_q))
		else $error("partial remainder not below modulus");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("multiply done without a running multiply");

endmodule

// ===== src/mexp_datapath.sv =====
// Datapath: configuration registers, operand registers, bit counter, multiplier.
module mexp_datapath #(
	parameter int WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [mexp_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  logic [mexp_pkg::FIELD_W-1:0]    cfg_wdata,
	input  logic [mexp_pkg::FIELD_W-1:0]    message,
	input  mexp_pkg::cmd_t                  cmd,
	output mexp_pkg::status_t               status,
	output logic [mexp_pkg::FIELD_W-1:0]    result
);
	import mexp_pkg::*;

	// exponent bits above the field width are zero, so only VW bits are scanned
	localparam int VW = (WIDTH < FIELD_W) ? WIDTH : FIELD_W;
	localparam int CW = $clog2(VW);

	logic [VW-1:0] modulus_q;
	logic [VW-1:0] exponent_q;

	logic [VW-1:0] n_q;
	logic [VW-1:0] e_q;
	logic [VW-1:0] msg_q;
	logic [VW-1:0] acc_q;
	logic [VW-1:0] base_q;
	logic [CW-1:0] cnt_q;
	op_t           op_q;

	logic [VW-1:0] mul_a;
	logic [VW-1:0] mul_b;
	logic [VW-1:0] mul_p;
	logic          mul_busy;
	logic          mul_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q  <= VW'(2);
			exponent_q <= VW'(1);
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_MODULUS:  modulus_q  <= cfg_wdata[VW-1:0];
				CFG_EXPONENT: exponent_q <= cfg_wdata[VW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cmd.op)
			OP_REDUCE: begin
				mul_a = msg_q;
				mul_b = VW'(1);
			end
			OP_MUL: begin
				mul_a = acc_q;
				mul_b = base_q;
			end
			OP_SQR: begin
				mul_a = base_q;
				mul_b = base_q;
			end
			default: begin
				mul_a = base_q;
				mul_b = base_q;
			end
		endcase
	end

	mexp_mulmod #(.VW(VW)) u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.n      (n_q),
		.busy   (mul_busy),
		.done   (mul_done),
		.p      (mul_p)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q   <= modulus_q;
			e_q   <= exponent_q;
			msg_q <= message[VW-1:0];
			acc_q <= VW'(1);
			cnt_q <= '0;
		end else begin
			if (cmd.clear)
				acc_q <= '0;
			if (mul_done) begin
				case (op_q)
					OP_MUL:  acc_q  <= mul_p;
					default: base_q <= mul_p;
				endcase
			end
			if (cmd.shift) begin
				e_q   <= e_q >> 1;
				cnt_q <= cnt_q + 1'b1;
			end
		end
		if (cmd.mul_start)
			op_q <= cmd.op;
	end

	always_comb begin
		status.mul_busy = mul_busy;
		status.mul_done = mul_done;
		status.e_bit    = e_q[0];
		status.last_bit = (cnt_q == CW'(VW - 1));
		status.n_small  = (n_q < VW'(2));
	end

	assign result = FIELD_W'(acc_q);

endmodule

// ===== src/mexp_ctrl.sv =====
// Controller: sequences reduction, multiply and square steps per exponent bit.
module mexp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  mexp_pkg::status_t  status,
	output mexp_pkg::cmd_t     cmd,
	output logic               busy,
	output logic               done
);
	import mexp_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_CHK  = 7'b0000010,
		S_WRED = 7'b0000100,
		S_BIT  = 7'b0001000,
		S_WMUL = 7'b0010000,
		S_WSQR = 7'b0100000,
		S_DONE = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   idle;

	assign idle = (state_q == S_IDLE) || (state_q == S_DONE);

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.op        = OP_SQR;
		case (state_q)
			S_IDLE, S_DONE: begin
				state_d = S_IDLE;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_CHK;
				end
			end
			S_CHK: begin
				if (status.n_small) begin
					cmd.clear = 1'b1;
					state_d   = S_DONE;
				end else begin
					cmd.mul_start = 1'b1;
					cmd.op        = OP_REDUCE;
					state_d       = S_WRED;
				end
			end
			S_WRED: begin
				if (status.mul_done)
					state_d = S_BIT;
			end
			S_BIT: begin
				cmd.mul_start = 1'b1;
				if (status.e_bit) begin
					cmd.op  = OP_MUL;
					state_d = S_WMUL;
				end else begin
					cmd.op  = OP_SQR;
					state_d = S_WSQR;
				end
			end
			S_WMUL: begin
				if (status.mul_done) begin
					cmd.mul_start = 1'b1;
					cmd.op        = OP_SQR;
					state_d       = S_WSQR;
				end
			end
			S_WSQR: begin
				if (status.mul_done) begin
					cmd.shift = 1'b1;
					state_d   = status.last_bit ? S_DONE : S_BIT;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	assign busy = !idle;
	assign done = (state_q == S_DONE);

	a_no_launch_busy: assert property (@(posedge clk) disable iff (!arst_n)
		status.mul_busy |-> !cmd.mul_start)
		else $error("multiply launched while multiplier busy");

	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not make block busy");

endmodule

// ===== tb/modular_exponentiation_tb.sv =====
`timescale 1ns / 100ps
// Testbench for modular_exponentiation: directed and random requests checked against a predictor.
module modular_exponentiation_tb;
	import mexp_pkg::*;

	// Bound for the slowest request: all-ones exponent, from start to done.
	localparam int LONGEST_REQUEST = 2180;
	// The watchdog trips after this many cycles with no request taken and no result seen.
	localparam int STALL_LIMIT     = 5 * LONGEST_REQUEST;
	// Quiet time after the last result, to catch stray done strobes.
	localparam int TAIL_CYCLES     = LONGEST_REQUEST + 100;
	localparam int MAX_REPORTS     = 10;
	localparam int RANDOM_SETTINGS = 6;   // register settings per idling phase
	localparam int RANDOM_REQUESTS = 15;  // requests per register setting

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_addr;
	logic [FIELD_W-1:0]   cfg_wdata;
	logic                 start;
	logic [FIELD_W-1:0]   message;
	logic                 busy;
	logic                 done;
	logic [FIELD_W-1:0]   result;

	// Local copy of the two registers, updated as they are written.
	logic [FIELD_W-1:0]   modulus_reg  = FIELD_W'(2);
	logic [FIELD_W-1:0]   exponent_reg = FIELD_W'(1);

	// Powers still owed by the block, oldest first.
	logic [FIELD_W-1:0]   pending_powers[$];
	int                   mismatches   = 0;
	int                   stall_cycles = 0;
	int                   sender_idle_pct = 0;

	modular_exponentiation dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.start     (start),
		.message   (message),
		.busy      (busy),
		.done      (done),
		.result    (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Right-to-left square and multiply at double width. A modulus below two
	// gives 0; an exponent of zero leaves the accumulator at 1.
	function automatic logic [FIELD_W-1:0] power_mod(input logic [FIELD_W-1:0] base_in,
			input logic [FIELD_W-1:0] power, input logic [FIELD_W-1:0] n_in);
		logic [2*FIELD_W-1:0] n;
		logic [2*FIELD_W-1:0] base;
		logic [2*FIELD_W-1:0] acc;
		if (n_in < 2)
			return '0;
		n    = {{FIELD_W{1'b0}}, n_in};
		base = {{FIELD_W{1'b0}}, base_in} % n;
		acc  = 1;
		for (int i = 0; i < FIELD_W; i++) begin
			if (power[i])
				acc = (acc * base) % n;
			base = (base * base) % n;
		end
		acc = acc % n;
		return acc[FIELD_W-1:0];
	endfunction

	// Random picks lean toward the edges: tiny and out-of-range moduli, all-ones
	// values, zero exponent, messages at multiples of the modulus.
	function automatic logic [FIELD_W-1:0] pick_modulus();
		case ($urandom_range(9))
			0: return FIELD_W'($urandom_range(15));
			1: return '1 - FIELD_W'($urandom_range(31));
			2: return FIELD_W'($urandom_range(65535));
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [FIELD_W-1:0] pick_exponent();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return FIELD_W'($urandom_range(255));
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [FIELD_W-1:0] pick_message();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return modulus_reg * FIELD_W'($urandom_range(3));
			3: return modulus_reg - FIELD_W'($urandom_range(1));
			default: return $urandom;
		endcase
	endfunction

	// Lower start and wait until every owed result is in and the block is free.
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (pending_powers.size() != 0 || busy);
	endtask

	// Registers change only while the block is idle: both are written back to back.
	task automatic load_registers(input logic [FIELD_W-1:0] mod_v,
			input logic [FIELD_W-1:0] exp_v);
		drain();
		cfg_we    <= 1'b1;
		cfg_addr  <= CFG_MODULUS;
		cfg_wdata <= mod_v;
		@(posedge clk);
		cfg_addr  <= CFG_EXPONENT;
		cfg_wdata <= exp_v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		modulus_reg  = mod_v;
		exponent_reg = exp_v;
	endtask

	// One request: optional idle cycles, then hold start until busy is seen low
	// at an edge. start stays high on return so back-to-back requests need no gap.
	task automatic send_message(input logic [FIELD_W-1:0] msg);
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start   <= 1'b1;
		message <= msg;
		do @(posedge clk); while (busy);
		pending_powers.push_back(power_mod(msg, exponent_reg, modulus_reg));
	endtask

	// Reset values: modulus 2, exponent 1, so the result is the message parity.
	task automatic test_reset_values();
		send_message('0);
		send_message(FIELD_W'(1));
		send_message('1);
		send_message(FIELD_W'(32'h8000_0000));
	endtask

	task automatic test_exponent_zero();
		load_registers('1, '0);
		send_message('0);
		send_message(FIELD_W'(5));
		load_registers(FIELD_W'(7), '0);
		send_message(FIELD_W'(14));
	endtask

	// Modulus zero or one is out of range and must give zero at once.
	task automatic test_small_modulus();
		load_registers('0, FIELD_W'(32'h1234_5678));
		send_message('1);
		send_message(FIELD_W'(9));
		load_registers(FIELD_W'(1), '1);
		send_message(FIELD_W'(3));
	endtask

	// Messages at or above the modulus get reduced before the first square.
	task automatic test_message_reduction();
		load_registers(FIELD_W'(13), FIELD_W'(5));
		send_message(FIELD_W'(13));
		send_message(FIELD_W'(26));
		send_message('1);
		send_message(FIELD_W'(12));
	endtask

	// Full-width operands: largest modulus, largest 32-bit prime, top exponent bits.
	task automatic test_extremes();
		load_registers('1, '1);
		send_message('1);
		send_message(FIELD_W'(32'hFFFF_FFFE));
		send_message('0);
		load_registers(FIELD_W'(32'hFFFF_FFFB), FIELD_W'(32'h8000_0000));
		send_message(FIELD_W'(32'hFFFF_FFFA));
		send_message(FIELD_W'(32'h7FFF_FFFF));
	endtask

	// Random settings and messages under three sender idling rates.
	task automatic test_random();
		int idle_rates[3] = '{19, 70, 0};
		foreach (idle_rates[p]) begin
			sender_idle_pct = idle_rates[p];
			for (int s = 0; s < RANDOM_SETTINGS; s++) begin
				load_registers(pick_modulus(), pick_exponent());
				for (int r = 0; r < RANDOM_REQUESTS; r++)
					send_message(pick_message());
			end
		end
	endtask

	// Result checker: done strobes for exactly one cycle and cannot be held off,
	// so every strobe seen at an edge is matched against the oldest owed power.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_powers.size() == 0) begin
				if (mismatches < MAX_REPORTS)
					$display("%0t: result %h arrived with no request outstanding",
						$time, result);
				mismatches = mismatches + 1;
			end else begin
				if (result !== pending_powers[0]) begin
					if (mismatches < MAX_REPORTS)
						$display("%0t: result expected %h, got %h",
							$time, pending_powers[0], result);
					mismatches = mismatches + 1;
				end
				void'(pending_powers.pop_front());
			end
		end
	end

	// Watchdog: any edge that takes a request or delivers a result clears it.
	always @(posedge clk) begin
		if ((start && !busy) || done)
			stall_cycles = 0;
		else
			stall_cycles = stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_addr  <= CFG_MODULUS;
		cfg_wdata <= '0;
		start     <= 1'b0;
		message   <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_exponent_zero();
		test_small_modulus();
		test_message_reduction();
		test_extremes();
		test_random();

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== files.f =====
src/mexp_pkg.sv
src/mexp_mulmod.sv
src/mexp_datapath.sv
src/mexp_ctrl.sv
src/modular_exponentiation.sv
tb/modular_exponentiation_tb.sv
